/* sv/tadc_pkg.sv */
// Shared types, widths and constants of the thermistor temperature converter.
package tadc_pkg;

  // Sample width default and fixed field widths
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int SER_W    = 20;
  localparam int COEF_W   = 40;
  localparam int CFG_W    = 40;
  localparam int TEMP_W   = 18;

  // Internal fixed-point widths
  localparam int R_W      = 40;  // resistance, Q24.16
  localparam int R_FRAC   = 16;
  localparam int IP_W     = 24;  // integer part of the resistance
  localparam int K_W      = 5;   // leading-one position
  localparam int LOG_FRAC = 24;
  localparam int X_W      = 26;  // mantissa, below 2.0 in Q24
  localparam int T_W      = 32;  // polynomial terms and the logarithm
  localparam int L2_W     = 36;
  localparam int L3_W     = 40;
  localparam int D_W      = 60;  // denominator, 2^-48 units
  localparam int D2_W     = 56;  // positive denominator as divisor
  localparam int N2_W     = 57;  // rounded dividend
  localparam int Q2_BITS  = 17;  // quotient bits in kelvin hundredths

  // Polynomial constants of ln(x), Q24
  localparam logic signed [T_W-1:0] P1 = 32'sd29222452;
  localparam logic signed [T_W-1:0] P2 = 32'sd47331925;
  localparam logic signed [T_W-1:0] P3 = 32'sd24661783;
  localparam logic signed [T_W-1:0] P4 = 32'sd7502428;
  localparam logic signed [T_W-1:0] P5 = 32'sd949101;
  localparam logic [T_W-1:0]        LN2_Q24 = 32'd11629080;

  // Register reset values
  localparam logic [SER_W-1:0]  SER_RESET    = 20'd10000;
  localparam logic [COEF_W-1:0] COEF_A_RESET = 40'd284078485605;
  localparam logic [COEF_W-1:0] COEF_B_RESET = 40'd66946160000;
  localparam logic [COEF_W-1:0] COEF_C_RESET = 40'd56835500;

  // Final scaling and saturation
  localparam logic [N2_W-1:0]          RECIP_NUM = 57'd28147497671065600;  // 100 * 2^48
  localparam logic [Q2_BITS-1:0]       TK_MAX    = 17'd127314;
  localparam logic signed [TEMP_W-1:0] K_OFFSET  = 18'sd27315;
  localparam logic signed [TEMP_W-1:0] TEMP_HI   = 18'sd99999;
  localparam logic signed [TEMP_W-1:0] TEMP_LO   = -18'sd27315;

  typedef enum logic [1:0] {
    STAT_VALID = 2'd0,
    STAT_OPEN  = 2'd1,
    STAT_SHORT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SERIES = 2'd0,
    REG_COEF_A = 2'd1,
    REG_COEF_B = 2'd2,
    REG_COEF_C = 2'd3
  } cfg_reg_t;

  // Flags that ride alongside the final division
  typedef struct packed {
    status_t st;
    logic    dz;
    logic    dneg;
    logic    ovf;
  } fin_flags_t;

endpackage

/* sv/tadc_ifs.sv */
// Valid/ready channel interfaces for samples and temperature results.
interface tadc_in_if import tadc_pkg::*; #(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface tadc_out_if import tadc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi_c;
  status_t                  status;

  modport source (output valid, output temp_centi_c, output status, input ready);
  modport sink   (input valid, input temp_centi_c, input status, output ready);
endinterface

/* sv/thermistor_adc_to_temperature.sv */
// Top level: thermistor divider sample to Steinhart-Hart temperature, pipelined.
//
//  channel   dir  words                          handshake
//  samples   in   adc_sample                     valid/ready
//  results   out  temp_centi_c, status           valid/ready
//  cfg       in   cfg_index, cfg_data            cfg_we, no wait
//
// One sample per cycle enters while samples.ready is high; the resistance divider
// works four bits a stage and the final 17-stage reciprocal divider one quotient
// bit a stage.
// rst is synchronous and clears valid bits and registers to their defaults.
// A stalled result waits in the output register; one more is caught in a skid
// register, and only then does the pipeline hold and samples.ready drop.
module thermistor_adc_to_temperature import tadc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  tadc_in_if.sink          samples,
  tadc_out_if.source       results
);

  localparam int NW1 = SER_W + SAMPLE_BITS + R_FRAC;
  localparam logic [SAMPLE_BITS-1:0] FULL = {SAMPLE_BITS{1'b1}};

  function automatic logic signed [T_W-1:0] qmul(input logic signed [T_W-1:0] a,
                                                 input logic signed [X_W-1:0] b);
    logic signed [T_W+X_W-1:0] p;
    p = a * b;
    return T_W'(p >>> LOG_FRAC);
  endfunction

  logic [SER_W-1:0]  series_ohms;
  logic [COEF_W-1:0] coef_a, coef_b, coef_c;

  logic en;
  logic out_v, skid_v;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      series_ohms <= SER_RESET;
      coef_a      <= COEF_A_RESET;
      coef_b      <= COEF_B_RESET;
      coef_c      <= COEF_C_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SERIES: series_ohms <= cfg_data[SER_W-1:0];
        REG_COEF_A: coef_a      <= cfg_data[COEF_W-1:0];
        REG_COEF_B: coef_b      <= cfg_data[COEF_W-1:0];
        REG_COEF_C: coef_c      <= cfg_data[COEF_W-1:0];
      endcase
    end
  end

  assign en            = !skid_v;
  assign samples.ready = en;

  // Stage a: take the sample, classify open and shorted sensor
  logic                   a_v;
  logic [SAMPLE_BITS-1:0] a_s;
  status_t                a_st;
  // Stage b: series * (full - s)
  logic                         b_v;
  logic [SER_W+SAMPLE_BITS-1:0] b_prod;
  logic [SAMPLE_BITS-1:0]       b_s;
  status_t                      b_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else if (en) begin
      a_v <= samples.valid;
      b_v <= a_v;
    end
    if (en) begin
      a_s <= samples.adc_sample;
      if (samples.adc_sample == '0) begin
        a_st <= STAT_OPEN;
      end else if (samples.adc_sample == FULL) begin
        a_st <= STAT_SHORT;
      end else begin
        a_st <= STAT_VALID;
      end
      b_prod <= series_ohms * (FULL - a_s);
      b_s    <= a_s;
      b_st   <= a_st;
    end
  end

  // Resistance divider: R = series*(F-s)*2^16 / s
  logic           c_v;
  logic [NW1-1:0] c_q;
  logic [1:0]     c_stb;

  tadc_div_pipe #(
    .NW(NW1), .DW(SAMPLE_BITS), .QB(NW1), .STEPS(4), .SW(2)
  ) u_rdiv (
    .clk(clk), .rst(rst), .en(en),
    .in_v(b_v), .num({b_prod, {R_FRAC{1'b0}}}), .den(b_s), .sb_in(b_st),
    .out_v(c_v), .quo(c_q), .sb_out(c_stb)
  );

  // Stage d: saturate R, find the leading one of its integer part
  logic           d_v;
  logic [R_W-1:0] d_r;
  logic [K_W-1:0] d_k;
  status_t        d_st;
  logic [R_W-1:0] r_sat;
  logic [K_W-1:0] k_next;

  always_comb begin
    r_sat  = (|c_q[NW1-1:R_W]) ? {R_W{1'b1}} : c_q[R_W-1:0];
    k_next = '0;
    for (int i = 1; i < IP_W; i++) begin
      if (r_sat[R_FRAC+i]) begin
        k_next = K_W'(i);
      end
    end
  end

  // Stage e: mantissa x and k*ln2
  logic                  e_v;
  logic signed [X_W-1:0] e_x;
  logic signed [T_W-1:0] e_kln;
  status_t               e_st;
  logic [R_W+7:0]        x_wide;

  assign x_wide = {d_r, 8'b0} >> d_k;

  // Stages f1..f4: Horner steps of the quartic; g: add k*ln2
  logic                  f1_v, f2_v, f3_v, f4_v, g_v;
  logic signed [T_W-1:0] f1_t, f2_t, f3_t, f4_t, g_l;
  logic signed [X_W-1:0] f1_x, f2_x, f3_x;
  logic signed [T_W-1:0] f1_kln, f2_kln, f3_kln, f4_kln;
  status_t               f1_st, f2_st, f3_st, f4_st, g_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v  <= 1'b0;
      e_v  <= 1'b0;
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      f4_v <= 1'b0;
      g_v  <= 1'b0;
    end else if (en) begin
      d_v  <= c_v;
      e_v  <= d_v;
      f1_v <= e_v;
      f2_v <= f1_v;
      f3_v <= f2_v;
      f4_v <= f3_v;
      g_v  <= f4_v;
    end
    if (en) begin
      d_r    <= r_sat;
      d_k    <= k_next;
      d_st   <= status_t'(c_stb);
      e_x    <= x_wide[X_W-1:0];
      e_kln  <= T_W'(d_k * LN2_Q24);
      e_st   <= d_st;
      f1_t   <= P4 - qmul(P5, e_x);
      f1_x   <= e_x;
      f1_kln <= e_kln;
      f1_st  <= e_st;
      f2_t   <= qmul(f1_t, f1_x) - P3;
      f2_x   <= f1_x;
      f2_kln <= f1_kln;
      f2_st  <= f1_st;
      f3_t   <= qmul(f2_t, f2_x) + P2;
      f3_x   <= f2_x;
      f3_kln <= f2_kln;
      f3_st  <= f2_st;
      f4_t   <= qmul(f3_t, f3_x) - P1;
      f4_kln <= f3_kln;
      f4_st  <= f3_st;
      g_l    <= f4_t + f4_kln;
      g_st   <= f4_st;
    end
  end

  // Stage h: L^2 and coef_b * |L| partial products
  logic                   h_v;
  logic signed [L2_W-1:0] h_l2;
  logic signed [T_W-1:0]  h_l;
  logic [COEF_W+7:0]      h_bh;
  logic [COEF_W+23:0]     h_bl;
  logic                   h_bneg;
  status_t                h_st;
  logic signed [2*T_W-1:0] sq;
  logic [T_W-1:0]          l_mag;

  always_comb begin
    sq    = g_l * g_l;
    l_mag = g_l[T_W-1] ? T_W'(-g_l) : T_W'(g_l);
  end

  // Stage i: L^3 and the signed coef_b term
  logic                   i_v;
  logic signed [L3_W-1:0] i_l3;
  logic signed [D_W-1:0]  i_pb;
  status_t                i_st;
  logic signed [L2_W+T_W-1:0] cu;
  logic [COEF_W+8:0]          pbm;
  logic signed [D_W-1:0]      pbs;

  always_comb begin
    cu  = h_l2 * h_l;
    pbm = (COEF_W+9)'(h_bh) + (COEF_W+9)'(h_bl >> LOG_FRAC);
    pbs = D_W'(pbm);
  end

  // Stage j: coef_c * |L^3| partial products, A plus the coef_b term
  logic                  j_v;
  logic [COEF_W+15:0]    j_ch;
  logic [COEF_W+23:0]    j_cl;
  logic                  j_cneg;
  logic signed [D_W-1:0] j_ab;
  status_t               j_st;
  logic [L3_W-1:0]       l3_mag;

  assign l3_mag = i_l3[L3_W-1] ? L3_W'(-i_l3) : L3_W'(i_l3);

  // Stage dd: full denominator D
  logic                  dd_v;
  logic signed [D_W-1:0] dd_d;
  status_t               dd_st;
  logic [COEF_W+16:0]    pcm;
  logic signed [D_W-1:0] pcs;

  always_comb begin
    pcm = (COEF_W+17)'(j_ch) + (COEF_W+17)'(j_cl >> LOG_FRAC);
    pcs = D_W'(pcm);
  end

  // Stage m: classify D, form the rounded dividend
  logic            m_v;
  logic [N2_W-1:0] m_np;
  logic [D2_W-1:0] m_ud;
  logic            m_dz, m_dneg;
  status_t         m_st;
  // Stage n: quotient overflow check
  logic            n_v;
  logic [N2_W-1:0] n_np;
  logic [D2_W-1:0] n_ud;
  fin_flags_t      n_fl;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v  <= 1'b0;
      i_v  <= 1'b0;
      j_v  <= 1'b0;
      dd_v <= 1'b0;
      m_v  <= 1'b0;
      n_v  <= 1'b0;
    end else if (en) begin
      h_v  <= g_v;
      i_v  <= h_v;
      j_v  <= i_v;
      dd_v <= j_v;
      m_v  <= dd_v;
      n_v  <= m_v;
    end
    if (en) begin
      h_l2   <= L2_W'(sq >>> LOG_FRAC);
      h_l    <= g_l;
      h_bh   <= coef_b * l_mag[T_W-1:LOG_FRAC];
      h_bl   <= coef_b * l_mag[LOG_FRAC-1:0];
      h_bneg <= g_l[T_W-1];
      h_st   <= g_st;
      i_l3   <= L3_W'(cu >>> LOG_FRAC);
      i_pb   <= h_bneg ? -pbs : pbs;
      i_st   <= h_st;
      j_ch   <= coef_c * l3_mag[L3_W-1:LOG_FRAC];
      j_cl   <= coef_c * l3_mag[LOG_FRAC-1:0];
      j_cneg <= i_l3[L3_W-1];
      j_ab   <= $signed(D_W'(coef_a)) + i_pb;
      j_st   <= i_st;
      dd_d   <= j_ab + (j_cneg ? -pcs : pcs);
      dd_st  <= j_st;
      m_dz   <= dd_d == '0;
      m_dneg <= dd_d[D_W-1];
      m_ud   <= dd_d[D2_W-1:0];
      m_np   <= RECIP_NUM + N2_W'(dd_d[D2_W-1:0] >> 1);
      m_st   <= dd_st;
      n_np   <= m_np;
      n_ud   <= m_ud;
      n_fl   <= '{st: m_st, dz: m_dz, dneg: m_dneg,
                  ovf: ({16'b0, m_np} >= {m_ud, {Q2_BITS{1'b0}}})};
    end
  end

  // Reciprocal divider: (100*2^48 + D/2) / D, 17 quotient bits
  logic               q2_v;
  logic [Q2_BITS-1:0] q2_q;
  fin_flags_t         q2_fl;

  tadc_div_pipe #(
    .NW(N2_W), .DW(D2_W), .QB(Q2_BITS), .STEPS(1), .SW($bits(fin_flags_t))
  ) u_tdiv (
    .clk(clk), .rst(rst), .en(en),
    .in_v(n_v), .num(n_np), .den(n_ud), .sb_in(n_fl),
    .out_v(q2_v), .quo(q2_q), .sb_out(q2_fl)
  );

  // Convert to Celsius hundredths and saturate
  logic                     fin_v;
  logic signed [TEMP_W-1:0] fin_temp;

  assign fin_v = en && q2_v;

  always_comb begin
    if (q2_fl.st != STAT_VALID) begin
      fin_temp = '0;
    end else if (q2_fl.dz) begin
      fin_temp = TEMP_HI;
    end else if (q2_fl.dneg) begin
      fin_temp = TEMP_LO;
    end else if (q2_fl.ovf || q2_q > TK_MAX) begin
      fin_temp = TEMP_HI;
    end else begin
      fin_temp = $signed({1'b0, q2_q}) - K_OFFSET;
    end
  end

  // Output register and skid register
  logic signed [TEMP_W-1:0] out_temp, skid_temp;
  status_t                  out_st, skid_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || results.ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= fin_v;
      end
    end else if (fin_v) begin
      skid_v <= 1'b1;
    end
    if (!out_v || results.ready) begin
      out_temp <= skid_v ? skid_temp : fin_temp;
      out_st   <= skid_v ? skid_st : q2_fl.st;
    end else if (fin_v) begin
      skid_temp <= fin_temp;
      skid_st   <= q2_fl.st;
    end
  end

  assign results.valid        = out_v;
  assign results.temp_centi_c = out_temp;
  assign results.status       = out_st;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid register holds a word while the output register is empty");

  a_catch_stall: assert property (@(posedge clk) disable iff (rst)
    (out_v && !results.ready && fin_v) |=> skid_v)
    else $error("result leaving the pipeline under a stall was not caught");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status != STAT_VALID) |-> (results.temp_centi_c == '0))
    else $error("sensor fault word carries a nonzero temperature");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == STAT_VALID) |->
      (results.temp_centi_c >= TEMP_LO && results.temp_centi_c <= TEMP_HI))
    else $error("temperature outside the saturation range");

endmodule

/* sv/tadc_div_pipe.sv */
// Pipelined restoring divider, STEPS quotient bits per stage, the last stage taking what remains.
module tadc_div_pipe #(
  parameter int NW    = 46,
  parameter int DW    = 10,
  parameter int QB    = 46,
  parameter int STEPS = 4,
  parameter int SW    = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] sb_in,
  output logic          out_v,
  output logic [QB-1:0] quo,
  output logic [SW-1:0] sb_out
);

  localparam int NS = (QB + STEPS - 1) / STEPS;

  logic          v_w   [NS];
  logic [DW-1:0] rem_w [NS];
  logic [QB-1:0] nq_w  [NS];
  logic [DW-1:0] dv_w  [NS];
  logic [SW-1:0] sb_w  [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [QB-1:0] nq_in;
    logic [DW-1:0] dv_in;
    logic [SW-1:0] sb_i;
    logic [DW-1:0] rem_next;
    logic [QB-1:0] nq_next;
    logic          v_q;
    logic [DW-1:0] rem_q;
    logic [QB-1:0] nq_q;
    logic [DW-1:0] dv_q;
    logic [SW-1:0] sb_q;

    if (g == 0) begin : g_first
      // upper dividend bits start the remainder, the rest shift in
      assign v_in   = in_v;
      assign rem_in = DW'(num >> QB);
      assign nq_in  = num[QB-1:0];
      assign dv_in  = den;
      assign sb_i   = sb_in;
    end else begin : g_next
      assign v_in   = v_w[g-1];
      assign rem_in = rem_w[g-1];
      assign nq_in  = nq_w[g-1];
      assign dv_in  = dv_w[g-1];
      assign sb_i   = sb_w[g-1];
    end

    // shift in STEPS dividend bits one at a time, subtract when it fits
    always_comb begin
      logic [DW:0] t;
      t        = '0;
      rem_next = rem_in;
      nq_next  = nq_in;
      for (int j = 0; j < STEPS; j++) begin
        if (g * STEPS + j < QB) begin
          t = {rem_next, nq_next[QB-1]};
          if (t >= {1'b0, dv_in}) begin
            rem_next = DW'(t - {1'b0, dv_in});
            nq_next  = {nq_next[QB-2:0], 1'b1};
          end else begin
            rem_next = t[DW-1:0];
            nq_next  = {nq_next[QB-2:0], 1'b0};
          end
        end
      end
    end

    // advance the stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q <= 1'b0;
      end else if (en) begin
        v_q <= v_in;
      end
      if (en) begin
        rem_q <= rem_next;
        nq_q  <= nq_next;
        dv_q  <= dv_in;
        sb_q  <= sb_i;
      end
    end

    assign v_w[g]   = v_q;
    assign rem_w[g] = rem_q;
    assign nq_w[g]  = nq_q;
    assign dv_w[g]  = dv_q;
    assign sb_w[g]  = sb_q;
  end

  assign out_v  = v_w[NS-1];
  assign quo    = nq_w[NS-1];
  assign sb_out = sb_w[NS-1];

endmodule

/* tb/testbench.sv */
// Testbench for the thermistor sample to temperature converter: predicted results checked in order.
module testbench import tadc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    status_t                  st;
  } temp_word_t;

  localparam longint C1  = 29222452;
  localparam longint C2  = 47331925;
  localparam longint C3  = 24661783;
  localparam longint C4  = 7502428;
  localparam longint C5  = 949101;
  localparam longint CLN = 11629080;
  localparam logic [63:0] RES_CAP = 64'hFF_FFFF_FFFF;
  localparam logic [39:0] COEF_TOP = 40'hFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_SERIES;
  logic [CFG_W-1:0] cfg_data = '0;

  tadc_in_if #(.SAMPLE_BITS(10)) samples_if ();
  tadc_out_if results_if ();

  thermistor_adc_to_temperature #(.SAMPLE_BITS(10)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .samples(samples_if.sink), .results(results_if.source)
  );

  always #2 clk = ~clk;

  // Register copies for the predictor
  logic [63:0] ser_q = 64'd10000;
  logic [63:0] ca_q = 64'd284078485605;
  logic [63:0] cb_q = 64'd66946160000;
  logic [63:0] cc_q = 64'd56835500;

  temp_word_t temp_due[$];
  int fail_count = 0;
  int words_seen = 0;
  int samples_sent = 0;
  int cfg_writes = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_on = 1'b0;

  initial begin
    samples_if.valid = 1'b0;
    samples_if.adc_sample = '0;
    results_if.ready = 1'b0;
  end

  function automatic longint qmul24(longint a, longint b);
    return (a * b) >>> 24;
  endfunction

  // Coefficient times signed Q24 value, magnitude truncated, 64-bit wrap kept
  function automatic longint coef_mul(logic [63:0] c, longint v);
    logic [63:0] m, hi, lo, p;
    m = (v < 0) ? 64'(-v) : 64'(v);
    hi = m >> 24;
    lo = m & 64'hFF_FFFF;
    p = c * hi + ((c * lo) >> 24);
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic temp_word_t predict_temp(logic [9:0] s);
    temp_word_t w;
    logic [63:0] r, ip, num, ud, tk;
    longint k, x, t, l, l3, d, tmp;
    w.temp = '0;
    if (s == 10'd0) begin
      w.st = STAT_OPEN;
      return w;
    end
    if (s == 10'd1023) begin
      w.st = STAT_SHORT;
      return w;
    end
    r = ((ser_q * (64'd1023 - 64'(s))) << 16) / 64'(s);
    if (r > RES_CAP) r = RES_CAP;
    ip = r >> 16;
    k = 0;
    while (ip > 1) begin
      ip = ip >> 1;
      k++;
    end
    x = longint'((r << 8) >> k);
    t = C4 - qmul24(C5, x);
    t = qmul24(t, x) - C3;
    t = qmul24(t, x) + C2;
    t = qmul24(t, x) - C1;
    l = t + k * CLN;
    l3 = qmul24(qmul24(l, l), l);
    d = longint'(ca_q) + coef_mul(cb_q, l) + coef_mul(cc_q, l3);
    if (d == 0) tmp = 99999;
    else if (d < 0) tmp = -27315;
    else begin
      num = 64'd100 << 48;
      ud = 64'(d);
      tk = (num + ud / 2) / ud;
      if (tk > 64'd127314) tmp = 99999;
      else tmp = longint'(tk) - 27315;
    end
    w.temp = tmp[TEMP_W-1:0];
    w.st = STAT_VALID;
    return w;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stalls
  always @(posedge clk) begin
    if (hold_on) results_if.ready <= 1'b0;
    else if (!stalls_on) results_if.ready <= 1'b1;
    else results_if.ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : ($urandom_range(0, 9) != 0);
  end

  task automatic force_hold();
    // drop ready for a long stretch, then resume
    hold_on = 1'b1;
    repeat ($urandom_range(20, 50)) @(posedge clk);
    hold_on = 1'b0;
  endtask

  // Long receiver stalls now and then
  initial begin
    forever begin
      repeat ($urandom_range(200, 600)) @(posedge clk);
      if (stalls_on) force_hold();
    end
  end

  // Check each accepted result word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      words_seen++;
      if (temp_due.size() == 0) begin
        $error("result word with nothing expected: temp_centi_c %0d status %0d",
               results_if.temp_centi_c, results_if.status);
        fail_count++;
      end else begin
        temp_word_t e;
        e = temp_due.pop_front();
        if (results_if.temp_centi_c !== e.temp) begin
          $error("temp_centi_c expected %0d actual %0d", e.temp, results_if.temp_centi_c);
          fail_count++;
        end
        if (results_if.status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, results_if.status);
          fail_count++;
        end
      end
    end
  end

  task automatic send_sample(logic [9:0] s);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.adc_sample <= s;
    do @(posedge clk); while (!samples_if.ready);
    temp_due.push_back(predict_temp(s));
    samples_sent++;
  endtask

  // Wait until every result is back, then let the pipeline empty
  task automatic drain();
    samples_if.valid <= 1'b0;
    while (temp_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_SERIES: ser_q = 64'(val[SER_W-1:0]);
      REG_COEF_A: ca_q = 64'(val);
      REG_COEF_B: cb_q = 64'(val);
      default:    cc_q = 64'(val);
    endcase
    cfg_writes++;
  endtask

  task automatic set_all(logic [39:0] ser, logic [39:0] a, logic [39:0] b, logic [39:0] c);
    write_reg(REG_SERIES, ser);
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Reset values: extremes of the sample, both fault codes, walking bits
  task automatic test_reset_defaults();
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1);
    send_sample(10'd1022);
    send_sample(10'd512);
    for (int b = 0; b < 10; b++) send_sample(10'd1 << b);
    send_sample(10'h155);
    send_sample(10'h2AA);
    drain();
  endtask

  // Register extremes: zero series, zero and negative denominators, top values
  task automatic test_register_extremes();
    set_all(40'd0, COEF_A_RESET, COEF_B_RESET, COEF_C_RESET);
    send_sample(10'd300);
    send_sample(10'd1);
    drain();
    set_all(40'd10000, 40'd0, 40'd0, 40'd0);
    send_sample(10'd400);
    drain();
    set_all(40'd10000, 40'd0, COEF_TOP, 40'd0);
    send_sample(10'd1000);
    send_sample(10'd1022);
    drain();
    set_all(40'hF_FFFF, COEF_TOP, COEF_TOP, COEF_TOP);
    send_sample(10'd1);
    send_sample(10'd700);
    send_sample(10'd1022);
    drain();
    set_all(40'd1, 40'd1, 40'd1, COEF_TOP);
    send_sample(10'd1);
    send_sample(10'd1022);
    drain();
  endtask

  // Random settings, mostly valid samples with some fault codes
  task automatic test_random_mix();
    logic [39:0] ser, a, b, c;
    logic [9:0] s;
    int r;
    for (int ph = 0; ph < 8; ph++) begin
      gaps_on = (ph % 3) != 2;
      ser = ($urandom_range(0, 3) == 0) ? 40'($urandom_range(1, 20'hF_FFFF))
                                        : 40'($urandom_range(500, 200000));
      if (ph == 0) ser = 40'd10000;
      r = $urandom_range(0, 3);
      a = (r == 0) ? 40'({$urandom, $urandom})
                   : COEF_A_RESET + 40'($urandom_range(0, 1000000));
      b = (r == 0) ? 40'({$urandom, $urandom})
                   : COEF_B_RESET - 40'($urandom_range(0, 1000000));
      c = (r == 0) ? 40'({$urandom, $urandom})
                   : COEF_C_RESET + 40'($urandom_range(0, 100000));
      if (ph == 7) begin
        a = COEF_TOP;
        b = 40'd0;
        c = 40'd0;
      end
      set_all(ser, a, b, c);
      for (int n = 0; n < 150; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) s = 10'd0;
        else if (r < 6) s = 10'd1023;
        else s = 10'($urandom);
        send_sample(s);
      end
      drain();
    end
    set_all(SER_RESET, COEF_A_RESET, COEF_B_RESET, COEF_C_RESET);
    gaps_on = 1'b1;
    for (int n = 0; n < 50; n++) send_sample(10'($urandom));
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_mix();
    $display("sent %0d samples, checked %0d result words, %0d register writes",
             samples_sent, words_seen, cfg_writes);
    $display("covered fault codes, zero series, zero and negative denominators, saturation");
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
